// ===== rtl/core/glcd_pkg.sv =====
package glcd_pkg;

    // Default geometry of the two-controller panel
    localparam int DISPLAY_WIDTH_DEF  = 128;
    localparam int DISPLAY_HEIGHT_DEF = 64;

    // Request field widths
    localparam int ACTION_W = 2;
    localparam int X_W      = 7;
    localparam int Y_W      = 6;
    localparam int S_DATA_W = 16;

    // Result field widths
    localparam int PAGE_W   = 3;
    localparam int COL_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int M_DATA_W = 24;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_SET_DOT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_DOT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;         // latch request, read addressed byte
        logic dot_write;    // write modified byte, load dot result
        logic sweep_write;  // write zero at sweep address, advance sweep
        logic load_zero;    // load the clear-screen result
    } glcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_clear_all; // incoming request is a clear screen
        logic sweep_last;   // sweep address is at the last byte
        logic out_free;     // result register can take a new result
    } glcd_sts_t;

endpackage

// ===== rtl/core/glcd_ctrl.sv =====
module glcd_plot_fsm
    import glcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  glcd_sts_t  sts,
    output glcd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_DOT_WRITE,
        ST_CLR_SWEEP,
        ST_CLR_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Decode commands from the current state
    always_comb begin
        cmd.take        = ready_reg && s_tvalid;
        cmd.dot_write   = (state_reg == ST_DOT_WRITE) && sts.out_free;
        cmd.sweep_write = (state_reg == ST_INIT_SWEEP) || (state_reg == ST_CLR_SWEEP);
        cmd.load_zero   = (state_reg == ST_CLR_DONE) && sts.out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT_SWEEP: begin
                if (sts.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.is_clear_all ? ST_CLR_SWEEP : ST_DOT_WRITE;
                end
            end
            ST_DOT_WRITE: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_CLR_SWEEP: begin
                if (sts.sweep_last) state_next = ST_CLR_DONE;
            end
            ST_CLR_DONE: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // Hold state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_SWEEP;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// ===== rtl/core/glcd_dpath.sv =====
module glcd_dpath
    import glcd_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  glcd_cmd_t           cmd,
    output glcd_sts_t           sts
);

    localparam int PAGE_COUNT = DISPLAY_HEIGHT / 8;
    localparam int RAM_BYTES  = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int AW         = $clog2(RAM_BYTES);

    localparam logic [8:0]    WIDTH_9 = 9'(DISPLAY_WIDTH);
    localparam logic [3:0]    PAGES_4 = 4'(PAGE_COUNT);
    localparam logic [AW-1:0] WIDTH_A = AW'(DISPLAY_WIDTH);
    localparam logic [AW-1:0] LAST_A  = AW'(RAM_BYTES - 1);

    logic [ACTION_W-1:0] in_action;
    logic [X_W-1:0]      in_x;
    logic [Y_W-1:0]      in_y;
    logic [8:0]          x_ext;
    logic [8:0]          x_wrap;
    logic [3:0]          pg_wrap;
    logic [AW-1:0]       addr_in;

    logic [7:0]          mem [RAM_BYTES];
    logic [7:0]          rd_reg;
    logic [AW-1:0]       addr_reg;
    logic [ACTION_W-1:0] act_reg;
    logic                half_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [COL_W-1:0]    col_reg;
    logic [2:0]          bit_reg;
    logic [AW-1:0]       cnt_reg, cnt_next;

    logic [7:0]          mask;
    logic [7:0]          new_byte;

    logic                out_valid_reg;
    logic                out_half_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_dot_reg;

    // Unpack request: action, x, y from the lowest bit up
    assign in_action = s_tdata[1:0];
    assign in_x      = s_tdata[8:2];
    assign in_y      = s_tdata[14:9];

    // Wrap column into the display width
    assign x_ext  = {2'b00, in_x};
    assign x_wrap = (x_ext >= WIDTH_9) ? (x_ext - WIDTH_9) : x_ext;

    // Wrap page into the page count
    always_comb begin
        pg_wrap = {1'b0, in_y[5:3]};
        for (int i = 0; i < 8; i++) begin
            if (pg_wrap >= PAGES_4) pg_wrap = pg_wrap - PAGES_4;
        end
    end

    assign addr_in = AW'(pg_wrap) * WIDTH_A + AW'(x_wrap);

    // Latch request fields
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            addr_reg <= addr_in;
            act_reg  <= in_action;
            half_reg <= in_x[6];
            page_reg <= in_y[5:3];
            col_reg  <= in_x[5:0];
            bit_reg  <= in_y[2:0];
        end
    end

    // Modify the addressed bit
    assign mask = 8'h01 << bit_reg;
    always_comb begin
        case (act_reg)
            ACT_SET_DOT:   new_byte = rd_reg | mask;
            ACT_CLEAR_DOT: new_byte = rd_reg & ~mask;
            default:       new_byte = rd_reg ^ mask;
        endcase
    end

    // Display memory: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rd_reg <= mem[addr_in];
        end
        if (cmd.sweep_write) begin
            mem[cnt_reg] <= 8'h00;
        end else if (cmd.dot_write) begin
            mem[addr_reg] <= new_byte;
        end
    end

    // Advance sweep address, back to zero after the last byte
    assign sts.sweep_last = (cnt_reg == LAST_A);
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.sweep_write) begin
            cnt_next = sts.sweep_last ? '0 : cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Result register
    assign sts.out_free     = !out_valid_reg || m_tready;
    assign sts.is_clear_all = (in_action == ACT_CLEAR_ALL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.dot_write || cmd.load_zero) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dot_write) begin
            out_half_reg <= half_reg;
            out_page_reg <= page_reg;
            out_col_reg  <= col_reg;
            out_byte_reg <= new_byte;
            out_dot_reg  <= rd_reg[bit_reg];
        end else if (cmd.load_zero) begin
            out_half_reg <= 1'b0;
            out_page_reg <= '0;
            out_col_reg  <= '0;
            out_byte_reg <= '0;
            out_dot_reg  <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_dot_reg, out_byte_reg, out_col_reg,
                       out_page_reg, out_half_reg};

endmodule

// ===== rtl/core/glcd_dot_plot_engine_top.sv =====
// Channel  | Direction | tdata fields (lowest bit up)
// ---------+-----------+----------------------------------------------------
// s_       | in        | action[1:0], x_coord[8:2], y_coord[14:9]
// m_       | out       | half_select[0], page_index[3:1], column_index[9:4],
//          |           | byte_written[17:10], dot_before[18]
//
// A dot request is accepted with the memory read, then written back.
// A clear-screen request zeroes the memory one byte per cycle through the single
// memory write port.
// After reset a clearing pass over all DISPLAY_WIDTH*(DISPLAY_HEIGHT/8) bytes (1024
// by default) zeroes the memory before s_tready rises.
// A stalled result holds in the output register; the write-back waits for it.
module glcd_dot_plot_engine_top
    import glcd_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // action, x_coord, y_coord
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // half, page, column, byte, dot
);

    glcd_cmd_t cmd;
    glcd_sts_t sts;

    glcd_plot_fsm u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    glcd_dpath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
